### src/interval_coverage_tracker_top_assert.svh
// ----------------------------------------------------------------------------
// Interval coverage tracker assertion macros
// Concurrent checks on clk, disabled while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef INTERVAL_COVERAGE_TRACKER_TOP_ASSERT_SVH
`define INTERVAL_COVERAGE_TRACKER_TOP_ASSERT_SVH

// check a consequence in the same cycle
`define ICOV_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// check a consequence in the next cycle
`define ICOV_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### src/icov_pkg.sv
// ----------------------------------------------------------------------------
// icov_pkg
// Shared types and defaults of the interval coverage tracker.
// ----------------------------------------------------------------------------
`default_nettype none

package icov_pkg;

	localparam int HOLES_DEF     = 16;
	localparam int ADDR_BITS_DEF = 32;
	localparam int FIELD_BITS    = 32;

	typedef enum logic [1:0] {
		ACT_ADD    = 2'd0,
		ACT_REMOVE = 2'd1,
		ACT_QUERY  = 2'd2,
		ACT_NONE   = 2'd3
	} action_t;

	typedef struct packed {
		action_t               action;
		logic [FIELD_BITS-1:0] range_low;
		logic [FIELD_BITS-1:0] range_high;
	} in_word_t;

	typedef struct packed {
		logic covered;
		logic table_full;
	} out_word_t;

	typedef struct packed {
		logic load;
		logic span;
		logic scan;
		logic split_wr;
		logic out_load;
	} cmd_t;

	typedef struct packed {
		logic scan_op;
		logic split;
		logic last;
	} stat_t;

endpackage

`default_nettype wire

### src/icov_ctrl.sv
// ----------------------------------------------------------------------------
// icov_ctrl
// Sequencer: span step, hole table scan, split writes, result handoff.
// ----------------------------------------------------------------------------
`default_nettype none

module icov_ctrl import icov_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  item_valid,
	output logic  item_stall,
	output logic  result_valid,
	input  logic  result_stall,
	input  stat_t st,
	output cmd_t  cmd
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_SPAN,
		S_SCAN,
		S_SPLIT,
		S_DONE
	} state_t;

	state_t state_q;
	logic   result_valid_q;

	assign item_stall   = (state_q != S_IDLE);
	assign result_valid = result_valid_q;

	always_comb begin
		cmd          = '0;
		cmd.load     = (state_q == S_IDLE) && item_valid;
		cmd.span     = (state_q == S_SPAN);
		cmd.scan     = (state_q == S_SCAN);
		cmd.split_wr = (state_q == S_SPLIT);
		cmd.out_load = (state_q == S_DONE) && (!result_valid_q || !result_stall);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= S_IDLE;
			result_valid_q <= 1'b0;
		end else begin
			if (cmd.out_load) begin
				result_valid_q <= 1'b1;
			end else if (result_valid_q && !result_stall) begin
				result_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (item_valid) begin
						state_q <= S_SPAN;
					end
				end
				S_SPAN: begin
					state_q <= st.scan_op ? S_SCAN : S_DONE;
				end
				S_SCAN: begin
					priority if (st.split) begin
						state_q <= S_SPLIT;
					end else if (st.last) begin
						state_q <= S_DONE;
					end else begin
						state_q <= S_SCAN;
					end
				end
				S_SPLIT: begin
					state_q <= st.last ? S_DONE : S_SCAN;
				end
				S_DONE: begin
					if (cmd.out_load) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

`default_nettype wire

### src/icov_dp.sv
// ----------------------------------------------------------------------------
// icov_dp
// Span registers, hole memory with valid bits, scan pipeline and compares.
// ----------------------------------------------------------------------------
`default_nettype none

module icov_dp import icov_pkg::*; #(
	parameter int HOLES     = HOLES_DEF,
	parameter int ADDR_BITS = ADDR_BITS_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	input  in_word_t  item,
	input  cmd_t      cmd,
	output stat_t     st,
	output out_word_t result
);

	localparam int W  = ADDR_BITS;
	localparam int IW = $clog2(HOLES);
	localparam int CW = $clog2(HOLES + 1);

	action_t        act_q;
	logic [W-1:0]   a_q;
	logic [W-1:0]   b_q;
	logic [W-1:0]   span_lo_q;
	logic [W-1:0]   span_hi_q;
	logic [HOLES-1:0] valid_q;
	logic [HOLES-1:0] fresh_q;
	logic [2*W-1:0] hole_mem_q [HOLES];
	logic [2*W-1:0] rd_s1;
	logic [IW-1:0]  e_idx_s1;
	logic           e_vld_s1;
	logic [CW-1:0]  rd_ptr_q;
	logic [IW-1:0]  split_idx_q;
	logic [W-1:0]   split_hi_q;
	logic           cov_q;
	logic           full_q;
	out_word_t      result_q;

	logic           free_ok;
	logic [IW-1:0]  free_idx;
	logic [W-1:0]   lo;
	logic [W-1:0]   hi;
	logic           is_add;
	logic           is_rem;
	logic           is_qry;
	logic           ent_live;
	logic           do_eval;
	logic           cover_all;
	logic           inner;
	logic           top_cut;
	logic           bot_cut;
	logic           hit;
	logic           split_any;
	logic           adv;
	logic           rd_en;
	logic           span_empty;
	logic           gap_hi;
	logic           gap_lo;
	logic           span_put;
	logic [2*W-1:0] span_put_data;
	logic           we;
	logic [IW-1:0]  wa;
	logic [2*W-1:0] wd;

	always_comb begin
		free_ok  = 1'b0;
		free_idx = '0;
		for (int k = HOLES - 1; k >= 0; k--) begin
			if (!valid_q[k]) begin
				free_ok  = 1'b1;
				free_idx = IW'(k);
			end
		end
	end

	assign lo     = rd_s1[2*W-1:W];
	assign hi     = rd_s1[W-1:0];
	assign is_add = (act_q == ACT_ADD);
	assign is_rem = (act_q == ACT_REMOVE);
	assign is_qry = (act_q == ACT_QUERY);

	assign ent_live  = e_vld_s1 && valid_q[e_idx_s1] && !fresh_q[e_idx_s1];
	assign do_eval   = cmd.scan && ent_live;
	assign cover_all = (a_q <= lo) && (b_q >= hi);
	assign inner     = (a_q > lo) && (b_q < hi);
	assign top_cut   = (b_q > lo) && (b_q < hi);
	assign bot_cut   = (a_q < hi) && (a_q > lo);
	assign hit       = ((a_q < lo) && (b_q > hi)) || ((a_q >= lo) && (a_q < hi))
		|| ((b_q > lo) && (b_q <= hi));
	assign split_any = do_eval && is_add && !cover_all && inner;

	assign st.split   = split_any && free_ok;
	assign st.last    = e_vld_s1 && (e_idx_s1 == IW'(HOLES - 1));
	assign st.scan_op = is_add || is_qry;

	assign adv   = (cmd.scan && !st.split) || cmd.split_wr;
	assign rd_en = adv && (rd_ptr_q < CW'(HOLES));

	assign span_empty    = (span_lo_q == span_hi_q);
	assign gap_hi        = (a_q > span_hi_q);
	assign gap_lo        = (b_q < span_lo_q);
	assign span_put      = cmd.span && (is_rem || (is_add && !span_empty && (gap_hi || gap_lo)));
	assign span_put_data = is_rem ? {a_q, b_q} : (gap_hi ? {span_hi_q, a_q} : {b_q, span_lo_q});

	always_comb begin
		we = 1'b0;
		wa = free_idx;
		wd = span_put_data;
		priority if (span_put) begin
			we = free_ok;
		end else if (do_eval && is_add && !cover_all && (inner || top_cut || bot_cut)) begin
			we = 1'b1;
			wa = e_idx_s1;
			wd = inner ? {lo, a_q} : (top_cut ? {b_q, hi} : {lo, a_q});
		end else if (cmd.split_wr) begin
			we = 1'b1;
			wa = split_idx_q;
			wd = {b_q, split_hi_q};
		end else begin
			we = 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (we) begin
			hole_mem_q[wa] <= wd;
		end
		if (rd_en) begin
			rd_s1 <= hole_mem_q[rd_ptr_q[IW-1:0]];
		end
		if (cmd.load) begin
			act_q <= item.action;
			a_q   <= W'(item.range_low);
			b_q   <= W'(item.range_high);
		end
		if (split_any) begin
			split_idx_q <= free_idx;
			split_hi_q  <= hi;
		end
		if (cmd.out_load) begin
			result_q <= '{covered: cov_q, table_full: full_q};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			span_lo_q <= '0;
			span_hi_q <= '0;
			valid_q   <= '0;
			fresh_q   <= '0;
			e_idx_s1  <= '0;
			e_vld_s1  <= 1'b0;
			rd_ptr_q  <= '0;
			cov_q     <= 1'b0;
			full_q    <= 1'b0;
		end else begin
			if (cmd.load) begin
				fresh_q <= '0;
				cov_q   <= 1'b0;
				full_q  <= 1'b0;
			end
			if (cmd.span) begin
				rd_ptr_q <= '0;
				e_vld_s1 <= 1'b0;
				if (is_qry) begin
					cov_q <= !((a_q < span_lo_q) || (b_q > span_hi_q));
				end
				if (is_add) begin
					priority if (span_empty) begin
						span_lo_q <= a_q;
						span_hi_q <= b_q;
					end else if (gap_hi) begin
						span_hi_q <= b_q;
					end else if (gap_lo) begin
						span_lo_q <= a_q;
					end else begin
						if (a_q < span_lo_q) begin
							span_lo_q <= a_q;
						end
						if (b_q > span_hi_q) begin
							span_hi_q <= b_q;
						end
					end
				end
			end
			if (span_put) begin
				if (free_ok) begin
					valid_q[free_idx] <= 1'b1;
				end else begin
					full_q <= 1'b1;
				end
			end
			if (do_eval && is_add && cover_all) begin
				valid_q[e_idx_s1] <= 1'b0;
			end
			if (split_any) begin
				if (free_ok) begin
					valid_q[free_idx] <= 1'b1;
					fresh_q[free_idx] <= 1'b1;
				end else begin
					full_q <= 1'b1;
				end
			end
			if (do_eval && is_qry && hit) begin
				cov_q <= 1'b0;
			end
			if (adv) begin
				if (rd_ptr_q < CW'(HOLES)) begin
					e_idx_s1 <= rd_ptr_q[IW-1:0];
					e_vld_s1 <= 1'b1;
					rd_ptr_q <= rd_ptr_q + CW'(1);
				end else begin
					e_vld_s1 <= 1'b0;
				end
			end
		end
	end

	assign result = result_q;

endmodule

`default_nettype wire

### src/interval_coverage_tracker_top.sv
// ----------------------------------------------------------------------------
// interval_coverage_tracker_top
// Covered address intervals kept as one span minus a table of holes.
// ----------------------------------------------------------------------------
//  channel | handshake                 | word
//  item    | item_valid / item_stall   | in_word_t  (action, range_low, range_high)
//  result  | result_valid / result_stall | out_word_t (covered, table_full)
//
//  Remove and unknown actions go from the span step straight to the result handoff.
//  Add and query also scan the hole table, with one split write per hole split by an add;
//  the hole memory is read one entry per cycle during the scan, pausing when a split is found.
//  Reset clears span and valid bits at once; no clearing pass.
//  A waiting result does not block the next item; a stalled result holds.
// ----------------------------------------------------------------------------
`default_nettype none

module interval_coverage_tracker_top import icov_pkg::*; #(
	parameter int HOLES     = HOLES_DEF,
	parameter int ADDR_BITS = ADDR_BITS_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      item_valid,
	output logic      item_stall,
	input  in_word_t  item,
	output logic      result_valid,
	input  logic      result_stall,
	output out_word_t result
);

	cmd_t  cmd;
	stat_t st;

	icov_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.st           (st),
		.cmd          (cmd)
	);

	icov_dp #(
		.HOLES     (HOLES),
		.ADDR_BITS (ADDR_BITS)
	) u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item),
		.cmd    (cmd),
		.st     (st),
		.result (result)
	);

`include "interval_coverage_tracker_top_assert.svh"

	`ICOV_ASSERT_NXT(a_one_in_flight, item_valid && !item_stall, item_stall, "second word taken while busy")
	`ICOV_ASSERT_NXT(a_split_follows, st.split, cmd.split_wr, "split write skipped")
	`ICOV_ASSERT_NOW(a_no_clobber, cmd.out_load, !(result_valid && result_stall), "waiting result overwritten")

endmodule

`default_nettype wire
